// ===== src/cpc_pkg.sv =====
package cpc_pkg;

  // Operation codes
  localparam logic OP_TO_POLAR = 1'b0;
  localparam logic OP_TO_CART  = 1'b1;

  // Internal datapath widths: coordinates Q16, angles in degrees Q16
  localparam int XW = 36;
  localparam int ZW = 28;
  localparam int GW = 30;
  localparam int TABLE_LEN = 24;

  localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] DEG360 = ZW'(360 * 65536);

  // Output angle range, degrees with 8 fractional bits
  localparam int ANGLE_LIMIT = 46080;

  // Micro-rotation angles atan(2^-i) in degrees Q16
  localparam logic signed [ZW-1:0] ATAN_DEG [TABLE_LEN] = '{
    ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945),
    ZW'(234379),  ZW'(117304),  ZW'(58666),  ZW'(29335),
    ZW'(14668),   ZW'(7334),    ZW'(3667),   ZW'(1833),
    ZW'(917),     ZW'(458),     ZW'(229),    ZW'(115),
    ZW'(57),      ZW'(29),      ZW'(14),     ZW'(7),
    ZW'(4),       ZW'(2),       ZW'(1),      ZW'(0)
  };

  // Data handed from one stage to the next
  typedef struct packed {
    logic                 op;
    logic                 zero;
    logic                 flip;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cell_t;

  // Limit the step count to the angle table
  function automatic int clamp_steps(input int steps);
    int r;
    r = steps;
    if (r > TABLE_LEN) r = TABLE_LEN;
    if (r < 1) r = 1;
    return r;
  endfunction

  // Gain correction 1/K in Q30 for a given step count
  function automatic logic [GW-1:0] inv_gain(input int steps);
    int sh;
    sh = 2 * clamp_steps(steps);
    return GW'(652032874 + (434688583 >> sh));
  endfunction

endpackage

// ===== src/cpc_if.sv =====
interface cpc_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] re_in;
  logic [15:0] im_in;
  logic [15:0] radius_in;
  logic [16:0] angle_in;

  modport source (output valid, op, re_in, im_in, radius_in, angle_in, input ready);
  modport sink   (input valid, op, re_in, im_in, radius_in, angle_in, output ready);
endinterface

interface cpc_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] radius_out;
  logic [16:0] angle_out;
  logic [15:0] re_out;
  logic [15:0] im_out;
  logic        zero_radius;
  logic        saturated;

  modport source (output valid, radius_out, angle_out, re_out, im_out, zero_radius,
                  saturated, input ready);
  modport sink   (input valid, radius_out, angle_out, re_out, im_out, zero_radius,
                  saturated, output ready);
endinterface

// ===== src/cartesian_polar_converter_unit.sv =====
// Cartesian/polar converter on a pipelined CORDIC.
// Channels: item (sink) carries op with either (re_in, im_in) for op 0 or
// (radius_in, angle_in) for op 1; result (source) carries one transaction
// per item with radius_out, angle_out, re_out, im_out, zero_radius and
// saturated. Outputs that the operation does not produce read zero.
// Angles are degrees with 8 fractional bits.
// Stages: one input
// stage, one cell per micro-rotation, two output stages for the radius
// gain product and rounding. Throughput: one item per cycle while the
// receiver takes results, set by the chain of cells, each of which holds one item.
// Every stage has its own valid bit, so bubbles close up and a new item is
// accepted while earlier results wait. When the receiver stalls, the output
// register holds its result and the stages behind it fill; item.ready drops
// only once every stage is occupied.
// Reset clears all valid bits; no item is in flight afterwards and the
// block is ready in the first cycle after reset.
module cartesian_polar_converter_unit import cpc_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  cpc_item_if.sink     item,
  cpc_result_if.source result
);

  localparam int USED = clamp_steps(CORDIC_STEPS);

  cell_t          stage_data [USED+1];
  logic [USED:0]  stage_valid;
  logic [USED:0]  stage_ready;

  // Fold the input into the convergence range
  cpc_pre #(.STEPS(CORDIC_STEPS)) u_pre (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .dn_valid (stage_valid[0]),
    .dn_ready (stage_ready[0]),
    .dn_data  (stage_data[0])
  );

  // Chain of micro-rotation cells
  for (genvar k = 0; k < USED; k++) begin : g_cell
    cpc_cell #(.SHIFT(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stage_valid[k]),
      .up_ready (stage_ready[k]),
      .up_data  (stage_data[k]),
      .dn_valid (stage_valid[k+1]),
      .dn_ready (stage_ready[k+1]),
      .dn_data  (stage_data[k+1])
    );
  end

  // Gain correction, rounding and saturation
  cpc_post #(.STEPS(CORDIC_STEPS)) u_post (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stage_valid[USED]),
    .up_ready (stage_ready[USED]),
    .up_data  (stage_data[USED]),
    .result   (result)
  );

  // Accepted transaction enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> stage_valid[0])
    else $error("accepted item missing from first stage");

  // Refused conversion clears every other output
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.zero_radius |->
      result.radius_out == 16'd0 && result.angle_out == 17'd0 &&
      result.re_out == 16'd0 && result.im_out == 16'd0 && !result.saturated)
    else $error("zero radius result carries data");

  // Angle stays within its clamp
  a_angle: assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      $signed(result.angle_out) <= 17'sd46080 && $signed(result.angle_out) >= -17'sd46080)
    else $error("angle out of range");

  // Saturation flag only with a clipped coordinate
  a_sat: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |->
      result.re_out == 16'h7FFF || result.re_out == 16'h8000 ||
      result.im_out == 16'h7FFF || result.im_out == 16'h8000)
    else $error("saturated flag without clipped output");

endmodule

// ===== src/cpc_pre.sv =====
module cpc_pre import cpc_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  cpc_item_if.sink     item,
  output logic         dn_valid,
  input  logic         dn_ready,
  output cell_t        dn_data
);

  localparam logic [GW-1:0] GAIN = inv_gain(STEPS);

  logic                 load;
  cell_t                data_next;
  logic signed [XW-1:0] re_x;
  logic signed [XW-1:0] im_x;
  logic signed [ZW-1:0] za;
  logic signed [ZW-1:0] zw;
  logic [GW+16:0]       prod;

  assign item.ready = !dn_valid || dn_ready;
  assign load       = item.valid && item.ready;

  // Prepare the first cell: fold the half-plane or quadrant, scale the radius
  always_comb begin
    re_x = {{(XW-16){item.re_in[15]}}, item.re_in};
    im_x = {{(XW-16){item.im_in[15]}}, item.im_in};
    za   = {{(ZW-25){item.angle_in[16]}}, item.angle_in, 8'b0};
    prod = (GW+17)'(item.radius_in) * (GW+17)'(GAIN) + (GW+17)'(1 << 13);
    zw   = za;
    data_next = '0;
    data_next.op = item.op;
    if (item.op == OP_TO_POLAR) begin
      data_next.zero = (item.re_in == 16'd0) && (item.im_in == 16'd0);
      if (re_x < 0) begin
        data_next.x = -(re_x <<< 16);
        data_next.y = -(im_x <<< 16);
        data_next.z = im_x[XW-1] ? -DEG180 : DEG180;
      end else begin
        data_next.x = re_x <<< 16;
        data_next.y = im_x <<< 16;
        data_next.z = '0;
      end
    end else begin
      data_next.zero = (item.radius_in == 16'd0);
      // wrap once into [-180, 180], then fold into [-90, 90]
      if (za > DEG180) begin
        zw = za - DEG360;
      end else if (za < -DEG180) begin
        zw = za + DEG360;
      end
      if (zw > DEG90) begin
        data_next.z    = zw - DEG180;
        data_next.flip = 1'b1;
      end else if (zw < -DEG90) begin
        data_next.z    = zw + DEG180;
        data_next.flip = 1'b1;
      end else begin
        data_next.z = zw;
      end
      data_next.x = {{(XW-(GW+3)){1'b0}}, prod[GW+16:14]};
      data_next.y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (item.ready) begin
      dn_valid <= item.valid;
    end
  end

  // Hold payload unless a new transaction arrives
  always_ff @(posedge clk) begin
    if (load) begin
      dn_data <= data_next;
    end
  end

endmodule

// ===== src/cpc_cell.sv =====
module cpc_cell import cpc_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  cell_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output cell_t dn_data
);

  localparam logic signed [ZW-1:0] ANG = ATAN_DEG[SHIFT];

  logic                 fwd;
  logic signed [XW-1:0] xi;
  logic signed [XW-1:0] yi;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  cell_t                data_next;

  assign up_ready = !dn_valid || dn_ready;

  // One micro-rotation: drive y to zero (vectoring) or z to zero (rotation)
  always_comb begin
    xi = up_data.x;
    yi = up_data.y;
    dx = yi >>> SHIFT;
    dy = xi >>> SHIFT;
    if (up_data.op == OP_TO_POLAR) begin
      fwd = !yi[XW-1];
    end else begin
      fwd = up_data.z[ZW-1];
    end
    data_next = up_data;
    if (fwd) begin
      data_next.x = xi + dx;
      data_next.y = yi - dy;
      data_next.z = up_data.z + ANG;
    end else begin
      data_next.x = xi - dx;
      data_next.y = yi + dy;
      data_next.z = up_data.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= data_next;
    end
  end

endmodule

// ===== src/cpc_post.sv =====
module cpc_post import cpc_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  cell_t       up_data,
  cpc_result_if.source result
);

  localparam logic [GW-1:0]     GAIN   = inv_gain(STEPS);
  localparam logic signed [19:0] ANG_HI = 20'(ANGLE_LIMIT);
  localparam logic signed [19:0] ANG_LO = -20'(ANGLE_LIMIT);
  localparam logic signed [19:0] CRT_HI = 20'sd32767;
  localparam logic signed [19:0] CRT_LO = -20'sd32768;

  // first stage registers
  logic                 s1_valid;
  logic                 s1_ready;
  logic                 s1_keep;
  logic [GW+16:0]       p_hi;
  logic [GW+15:0]       p_lo;
  logic [16:0]          s1_angle;
  logic [15:0]          s1_re;
  logic [15:0]          s1_im;
  logic                 s1_zero;
  logic                 s1_sat;

  // output registers
  logic                 out_valid;
  logic                 s2_ready;
  logic [15:0]          radius;
  logic [16:0]          angle;
  logic [15:0]          re;
  logic [15:0]          im;
  logic                 zero;
  logic                 sat;

  logic [32:0]          mag;
  logic signed [ZW-1:0] za;
  logic signed [19:0]   ang_full;
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] yr;
  logic signed [19:0]   re_full;
  logic signed [19:0]   im_full;
  logic [16:0]          angle_next;
  logic [15:0]          re_next;
  logic [15:0]          im_next;
  logic                 sat_next;
  logic [63:0]          tot;
  logic [16:0]          rad_full;
  logic [15:0]          radius_next;

  assign s2_ready = !out_valid || result.ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign up_ready = s1_ready;

  // Round the angle, round and saturate the point, split the radius product
  always_comb begin
    mag      = up_data.x[XW-1] ? 33'd0 : up_data.x[32:0];
    za       = up_data.z + ZW'(128);
    ang_full = za[ZW-1:8];
    if (ang_full > ANG_HI) begin
      angle_next = ANG_HI[16:0];
    end else if (ang_full < ANG_LO) begin
      angle_next = ANG_LO[16:0];
    end else begin
      angle_next = ang_full[16:0];
    end
    xr = up_data.flip ? -up_data.x : up_data.x;
    yr = up_data.flip ? -up_data.y : up_data.y;
    xr = xr + XW'(32768);
    yr = yr + XW'(32768);
    re_full  = xr[XW-1:16];
    im_full  = yr[XW-1:16];
    sat_next = (re_full > CRT_HI) || (re_full < CRT_LO) ||
               (im_full > CRT_HI) || (im_full < CRT_LO);
    if (re_full > CRT_HI) begin
      re_next = CRT_HI[15:0];
    end else if (re_full < CRT_LO) begin
      re_next = CRT_LO[15:0];
    end else begin
      re_next = re_full[15:0];
    end
    if (im_full > CRT_HI) begin
      im_next = CRT_HI[15:0];
    end else if (im_full < CRT_LO) begin
      im_next = CRT_LO[15:0];
    end else begin
      im_next = im_full[15:0];
    end
    // drop outputs that the operation does not produce
    if (up_data.zero || up_data.op == OP_TO_CART) begin
      angle_next = '0;
    end
    if (up_data.zero || up_data.op == OP_TO_POLAR) begin
      re_next  = '0;
      im_next  = '0;
      sat_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && s1_ready) begin
      p_hi     <= (GW+17)'(mag[32:16]) * (GW+17)'(GAIN);
      p_lo     <= (GW+16)'(mag[15:0]) * (GW+16)'(GAIN);
      s1_keep  <= (up_data.op == OP_TO_POLAR) && !up_data.zero;
      s1_zero  <= up_data.zero;
      s1_angle <= angle_next;
      s1_re    <= re_next;
      s1_im    <= im_next;
      s1_sat   <= sat_next;
    end
  end

  // Sum the partial products, round the radius and saturate it to 16 bits
  always_comb begin
    tot = {1'b0, p_hi, 16'b0} + 64'(p_lo) + (64'd1 << 45);
    rad_full = tot[62:46];
    if (!s1_keep) begin
      radius_next = '0;
    end else if (rad_full[16]) begin
      radius_next = 16'hFFFF;
    end else begin
      radius_next = rad_full[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      radius <= radius_next;
      angle  <= s1_angle;
      re     <= s1_re;
      im     <= s1_im;
      zero   <= s1_zero;
      sat    <= s1_sat;
    end
  end

  assign result.valid       = out_valid;
  assign result.radius_out  = radius;
  assign result.angle_out   = angle;
  assign result.re_out      = re;
  assign result.im_out      = im;
  assign result.zero_radius = zero;
  assign result.saturated   = sat;

endmodule
